FILE: sv/pus_pkg.sv
package pus_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WALK_W    = CNT_W + 1;

  localparam int unsigned ACT_W = 2;
  localparam int unsigned POS_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 42;

  localparam int unsigned IN_FIELDS_W  = 3 * POS_W + VAL_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((SUM_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } val_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SUM_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } tree_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] total;
  } result_t;

  function automatic logic [SUM_W-1:0] sext_val(logic [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic [WALK_W-1:0] low_bit(logic [WALK_W-1:0] i);
    return i & (~i + WALK_W'(1));
  endfunction

endpackage

FILE: sv/point_update_range_sum.sv
// Channel  Dir  Handshake                   tdata (low bit up)                       tuser
// s_axis   in   s_axis_tvalid/s_axis_tready position, new_value, range_low,          action
//                                           range_high, zero pad to 64
// m_axis   out  m_axis_tvalid/m_axis_tready range_total, zero pad to 48              -
//
// After reset the partial-sum memory is cleared one entry a cycle, with s_axis_tready
// low. One item is taken at a time. An append walks the partial-sum entries upward, and
// an update first reads the old value, then walks the same way; the walk touches at most
// 11 entries. A query walks down from high+1 and then from low, reading each entry and
// then accumulating it on the single partial-sum read port.
// A query result waits in the output register; a later query stalls at its end until
// that register is free.
module point_update_range_sum
  import pus_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // position[9:0], new_value[41:10], range_low[51:42], range_high[61:52], pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // range_total[41:0], pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  item_t            item;
  result_t          res;
  val_req_t         val_req;
  tree_req_t        tree_req;
  logic [VAL_W-1:0] val_rdata;
  logic [SUM_W-1:0] tree_rdata;
  logic             out_free;
  logic             out_valid_q;
  logic [SUM_W-1:0] out_total_q;

  assign item.action     = s_axis_tuser;
  assign item.position   = s_axis_tdata[POS_W-1:0];
  assign item.new_value  = s_axis_tdata[POS_W+VAL_W-1:POS_W];
  assign item.range_low  = s_axis_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];
  assign item.range_high = s_axis_tdata[3*POS_W+VAL_W-1:2*POS_W+VAL_W];

  assign out_free = !out_valid_q || m_axis_tready;

  pus_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .out_free_i   (out_free),
    .result_o     (res),
    .val_req_o    (val_req),
    .val_rdata_i  (val_rdata),
    .tree_req_o   (tree_req),
    .tree_rdata_i (tree_rdata)
  );

  pus_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wdata_i (val_req.wdata),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

  pus_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ITEMS)) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_req.we),
    .waddr_i (tree_req.waddr),
    .wdata_i (tree_req.wdata),
    .raddr_i (tree_req.raddr),
    .rdata_o (tree_rdata)
  );

  // hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_total_q <= '0;
    end else begin
      if (res.valid) begin
        out_valid_q <= 1'b1;
        out_total_q <= res.total;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SUM_W){1'b0}}, out_total_q};

  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY)) |=> !s_axis_tready)
    else $error("item accepted while a query is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || m_axis_tready))
    else $error("result issued into an occupied output register");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res.valid))
    else $error("output valid without a finished query");

endmodule

FILE: sv/pus_ram.sv
module pus_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pus_seq.sv
module pus_seq
  import pus_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  logic             out_free_i,
  output result_t          result_o,
  output val_req_t         val_req_o,
  input  logic [VAL_W-1:0] val_rdata_i,
  output tree_req_t        tree_req_o,
  input  logic [SUM_W-1:0] tree_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_VREAD,
    S_URD,
    S_UWR,
    S_QRD,
    S_QACC,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  clr_q;
  logic [CNT_W-1:0]  count_q;
  logic [WALK_W-1:0] walk_q;
  logic [SUM_W-1:0]  delta_q;
  logic [SUM_W-1:0]  acc_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  lo_q;
  logic              phase_q;

  logic [IDX_W-1:0]  walk_idx;
  logic [WALK_W-1:0] walk_up;
  logic [WALK_W-1:0] walk_down;
  logic [CNT_W-1:0]  pos_e;
  logic [CNT_W-1:0]  lo_e;
  logic [CNT_W-1:0]  hi_e;
  logic [CNT_W-1:0]  hi_clip;
  logic              append_ok;

  assign walk_idx  = IDX_W'(walk_q - WALK_W'(1));
  assign walk_up   = walk_q + low_bit(walk_q);
  assign walk_down = walk_q - low_bit(walk_q);
  assign pos_e     = CNT_W'(item_i.position);
  assign lo_e      = CNT_W'(item_i.range_low);
  assign hi_e      = CNT_W'(item_i.range_high);
  assign hi_clip   = (hi_e >= count_q) ? (count_q - CNT_W'(1)) : hi_e;

  assign item_ready_o = (state_q == S_IDLE);
  assign append_ok    = item_valid_i && (state_q == S_IDLE) &&
                        (item_i.action == ACT_APPEND) &&
                        (count_q < CNT_W'(MAX_ITEMS));

  // Appended slots were never written before, so the old value is zero.
  always_comb begin
    val_req_o.raddr = IDX_W'(item_i.position);
    val_req_o.we    = append_ok || (state_q == S_VREAD);
    if (state_q == S_VREAD) begin
      val_req_o.waddr = walk_idx;
      val_req_o.wdata = val_q;
    end else begin
      val_req_o.waddr = IDX_W'(count_q);
      val_req_o.wdata = item_i.new_value;
    end
  end

  always_comb begin
    tree_req_o.raddr = walk_idx;
    tree_req_o.we    = 1'b0;
    tree_req_o.waddr = walk_idx;
    tree_req_o.wdata = tree_rdata_i + delta_q;
    case (state_q)
      S_CLEAR: begin
        tree_req_o.we    = 1'b1;
        tree_req_o.waddr = clr_q;
        tree_req_o.wdata = '0;
      end
      S_UWR: begin
        tree_req_o.we = 1'b1;
      end
      default: ;
    endcase
  end

  assign result_o.valid = (state_q == S_DONE) && out_free_i;
  assign result_o.total = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      walk_q  <= '0;
      delta_q <= '0;
      acc_q   <= '0;
      val_q   <= '0;
      lo_q    <= '0;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(MAX_ITEMS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid_i) begin
            case (item_i.action)
              ACT_APPEND: begin
                if (append_ok) begin
                  walk_q  <= WALK_W'(count_q) + WALK_W'(1);
                  delta_q <= sext_val(item_i.new_value);
                  count_q <= count_q + CNT_W'(1);
                  state_q <= S_URD;
                end
              end
              ACT_UPDATE: begin
                if (pos_e < count_q) begin
                  walk_q  <= WALK_W'(pos_e) + WALK_W'(1);
                  val_q   <= item_i.new_value;
                  state_q <= S_VREAD;
                end
              end
              ACT_QUERY: begin
                acc_q <= '0;
                if ((lo_e <= hi_e) && (lo_e < count_q)) begin
                  walk_q  <= WALK_W'(hi_clip) + WALK_W'(1);
                  lo_q    <= lo_e;
                  phase_q <= 1'b0;
                  state_q <= S_QRD;
                end else begin
                  state_q <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_VREAD: begin
          delta_q <= sext_val(val_q) - sext_val(val_rdata_i);
          state_q <= S_URD;
        end
        S_URD: begin
          state_q <= S_UWR;
        end
        S_UWR: begin
          walk_q <= walk_up;
          if (walk_up > WALK_W'(MAX_ITEMS)) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_URD;
          end
        end
        S_QRD: begin
          state_q <= S_QACC;
        end
        S_QACC: begin
          // first walk adds prefix(high+1), second subtracts prefix(low)
          acc_q <= phase_q ? (acc_q - tree_rdata_i) : (acc_q + tree_rdata_i);
          if (walk_down == '0) begin
            if (!phase_q && (lo_q != '0)) begin
              walk_q  <= WALK_W'(lo_q);
              phase_q <= 1'b1;
              state_q <= S_QRD;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            walk_q  <= walk_down;
            state_q <= S_QRD;
          end
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/tb_point_update_range_sum.sv
`timescale 1ns / 1ps

module tb_point_update_range_sum;
  import pus_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned IDLE_LIMIT  = 10000;
  localparam int unsigned TAIL_CYCLES = 100;

  // Mirror of the store: plain values, totals summed directly over the range.
  class range_total_tracker;
    logic [VAL_W-1:0] values [MAX_ITEMS];
    int unsigned      filled;
    logic [SUM_W-1:0] pending_totals [$];
    int unsigned      errors;

    function new();
      foreach (values[i]) values[i] = '0;
      filled = 0;
      errors = 0;
    endfunction

    function void note_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                            input logic [POS_W-1:0] hi);
      logic [SUM_W-1:0] total;
      int unsigned      top;
      total = '0;
      case (act)
        ACT_APPEND: begin
          if (filled < MAX_ITEMS) begin
            values[filled] = val;
            filled++;
          end
        end
        ACT_UPDATE: begin
          if (32'(pos) < filled) values[pos] = val;
        end
        ACT_QUERY: begin
          if (lo <= hi && 32'(lo) < filled) begin
            // clip the top of the range to the last filled position
            top = (32'(hi) >= filled) ? filled - 1 : 32'(hi);
            for (int unsigned i = 32'(lo); i <= top; i++)
              total = total + {{(SUM_W - VAL_W){values[i][VAL_W-1]}}, values[i]};
          end
          pending_totals.push_back(total);
        end
        default: ;
      endcase
    endfunction

    function void check_total(input logic [SUM_W-1:0] got);
      logic [SUM_W-1:0] want;
      if (pending_totals.size() == 0) begin
        $error("range_total: expected none, actual %0d", $signed(got));
        errors++;
      end else begin
        want = pending_totals.pop_front();
        if (want !== got) begin
          $error("range_total: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ACT_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  range_total_tracker tracker = new();

  bit          tx_steady;
  bit          rx_steady;
  bit          hold_req;
  int unsigned idle_cycles;

  point_update_range_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    return POS_W'($urandom());
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_W'({hi, lo, val, pos});
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(act, pos, val, lo, hi);
    @(negedge clk_i);
  endtask

  // mostly well-formed items against the current fill, the rest random noise
  task automatic send_mixed(input int unsigned append_pct);
    int unsigned      r;
    int unsigned      fill;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    r    = $urandom_range(0, 99);
    fill = tracker.filled;
    pos  = pick_pos();
    lo   = pick_pos();
    hi   = pick_pos();
    if (r < append_pct) begin
      send_item(ACT_APPEND, pos, pick_value(), lo, hi);
    end else if (r < append_pct + (100 - append_pct) / 2) begin
      if (fill > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, fill - 1));
      send_item(ACT_UPDATE, pos, pick_value(), lo, hi);
    end else if (r < 97) begin
      if (fill > 0 && $urandom_range(0, 9) < 7) begin
        lo = POS_W'($urandom_range(0, fill - 1));
        if ($urandom_range(0, 3) == 0) hi = POS_W'($urandom_range(32'(lo), MAX_ITEMS - 1));
        else hi = POS_W'($urandom_range(32'(lo), fill - 1));
      end
      send_item(ACT_QUERY, pos, pick_value(), lo, hi);
    end else begin
      send_item(ACT_UNUSED, pos, pick_value(), lo, hi);
    end
  endtask

  // drop the offer, then let every outstanding total come back
  task automatic wait_for_totals();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_totals.size() != 0) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned idle_left;
    idle_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        idle_left = pick_gap();
        m_axis_tready <= (idle_left == 0);
        if (idle_left > 0) idle_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_total(m_axis_tdata[SUM_W-1:0]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_APPEND;
    m_axis_tready = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty store, extremes, reversed and clipped ranges, ignored items
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd0, 10'd1023);
    send_item(ACT_UPDATE, 10'd0, 32'h1234_5678, pick_pos(), pick_pos());
    send_item(ACT_APPEND, pick_pos(), 32'h7fff_ffff, pick_pos(), pick_pos());
    send_item(ACT_APPEND, pick_pos(), 32'h8000_0000, pick_pos(), pick_pos());
    send_item(ACT_APPEND, pick_pos(), 32'hffff_ffff, pick_pos(), pick_pos());
    send_item(ACT_APPEND, pick_pos(), 32'h0000_0000, pick_pos(), pick_pos());
    send_item(ACT_APPEND, pick_pos(), 32'h0000_0001, pick_pos(), pick_pos());
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd0, 10'd4);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd1, 10'd1);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd3, 10'd1);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd2, 10'd1023);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd5, 10'd9);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd1023, 10'd1023);
    send_item(ACT_UPDATE, 10'd4, 32'h7fff_ffff, pick_pos(), pick_pos());
    send_item(ACT_UPDATE, 10'd5, 32'h8000_0000, pick_pos(), pick_pos());
    send_item(ACT_UPDATE, 10'd1023, 32'hffff_ffff, pick_pos(), pick_pos());
    send_item(ACT_UNUSED, pick_pos(), $urandom(), pick_pos(), pick_pos());
    send_item(ACT_QUERY, 10'h3ff, 32'hffff_ffff, 10'd0, 10'd1023);
    send_item(ACT_APPEND, 10'h3ff, 32'h7fff_ffff, 10'h3ff, 10'h3ff);
    send_item(ACT_QUERY, 10'd0, 32'd0, 10'd0, 10'd0);

    repeat (320) send_mixed(30);

    // sender pause: let every outstanding total come back
    wait_for_totals();

    hold_req = 1'b1;
    repeat (12) send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd0,
                          POS_W'($urandom_range(0, MAX_ITEMS - 1)));

    repeat (150) send_mixed(60);

    // late appends, then the whole store and the top positions
    repeat (3) send_item(ACT_APPEND, pick_pos(), pick_value(), pick_pos(), pick_pos());
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd0, 10'd1023);
    send_item(ACT_UPDATE, 10'd1023, 32'h8000_0000, pick_pos(), pick_pos());
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd1023, 10'd1023);
    send_item(ACT_QUERY, pick_pos(), $urandom(), 10'd1000, 10'd1023);

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (100) send_mixed(10);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (150) send_mixed(10);

    wait_for_totals();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
